// ===== rtl/utf8_line_edit_buffer_top_macros.svh =====
// Assertion macros used by the edit buffer sequencer.
`ifndef UTF8_LINE_EDIT_BUFFER_TOP_MACROS_SVH
`define UTF8_LINE_EDIT_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ULEB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ULEB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/uleb_pkg.sv =====
// Package: types, codes and the UTF-8 encoder of the line edit buffer.
`timescale 1ns / 1ps
package uleb_pkg;

	localparam int ULEB_CAPACITY = 256;
	localparam int POS_W         = 8;

	localparam logic [3:0] OP_INSERT    = 4'd0;
	localparam logic [3:0] OP_BACKSPACE = 4'd1;
	localparam logic [3:0] OP_DELETE    = 4'd2;
	localparam logic [3:0] OP_LEFT      = 4'd3;
	localparam logic [3:0] OP_RIGHT     = 4'd4;
	localparam logic [3:0] OP_HOME      = 4'd5;
	localparam logic [3:0] OP_END       = 4'd6;
	localparam logic [3:0] OP_PLACE     = 4'd7;
	localparam logic [3:0] OP_READ      = 4'd8;

	localparam logic [1:0] ST_CHANGED = 2'd0;
	localparam logic [1:0] ST_SAME    = 2'd1;
	localparam logic [1:0] ST_REJECT  = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [3:0]       opcode;
		logic [20:0]      codepoint;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] cursor_out;
		logic [7:0] length_out;
		logic [7:0] read_data;
	} rsp_t;

	// n is the byte count, zero for a rejected codepoint; b[0] goes first
	typedef struct packed {
		logic [2:0]      n;
		logic [3:0][7:0] b;
	} enc_t;

	function automatic enc_t enc_cp(logic [20:0] cp);
		enc_t e;
		e.n = 3'd0;
		e.b = '0;
		if (cp < 21'd32 || cp == 21'd127 || cp > 21'h10FFFF ||
			(cp >= 21'h00D800 && cp <= 21'h00DFFF)) begin
			e.n = 3'd0;
		end else if (cp < 21'h000080) begin
			e.n    = 3'd1;
			e.b[0] = cp[7:0];
		end else if (cp < 21'h000800) begin
			e.n    = 3'd2;
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h010000) begin
			e.n    = 3'd3;
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
		end else begin
			e.n    = 3'd4;
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
		end
		return e;
	endfunction

endpackage

// ===== rtl/uleb_mem.sv =====
// Text byte store: one write port, one read port with registered data.
`timescale 1ns / 1ps
module uleb_mem
	import uleb_pkg::*;
#(
	parameter int DEPTH = ULEB_CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] ram [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			ram[waddr] <= wdata;
		end
		if (re) begin
			rdata <= ram[raddr];
		end
	end

endmodule

// ===== rtl/uleb_ctrl.sv =====
// Sequencer: decodes requests, scans for boundaries, shifts the tail, writes encodings.
`timescale 1ns / 1ps
`include "utf8_line_edit_buffer_top_macros.svh"
module uleb_ctrl
	import uleb_pkg::*;
#(
	parameter int CAPACITY = ULEB_CAPACITY,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  req_t          req_data,
	output logic          req_stall,
	output logic          res_valid,
	output rsp_t          res_data,
	input  logic          res_ready,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [7:0]    mem_rdata
);

	localparam int CW = (AW > POS_W) ? AW : POS_W;
	localparam logic [AW:0] CAP_X = (AW+1)'(CAPACITY);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b00000001,
		S_SCAN_RD  = 8'b00000010,
		S_SCAN_CHK = 8'b00000100,
		S_SCAN_END = 8'b00001000,
		S_SHIFT    = 8'b00010000,
		S_ENC      = 8'b00100000,
		S_RD_WAIT  = 8'b01000000,
		S_FIN      = 8'b10000000
	} state_t;

	state_t        state_q;
	logic [3:0]    op_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] len_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] src_q;
	logic [AW-1:0] dist_q;
	logic          more_q;
	logic          wr_vld_s1;
	logic [AW-1:0] wr_addr_s1;
	enc_t          enc_q;
	logic [1:0]    k_q;
	logic [1:0]    status_q;
	logic [7:0]    rd_q;

	enc_t          enc_w;
	logic [AW:0]   len_plus_n;
	logic          pos_lt_len;
	logic [AW-1:0] pos_a;
	logic          scan_fwd;
	logic          scan_stop;
	logic          shift_up;
	logic          accept;

	assign accept     = req_valid && (state_q == S_IDLE);
	assign req_stall  = (state_q != S_IDLE);
	assign enc_w      = enc_cp(req_data.codepoint);
	assign len_plus_n = {1'b0, len_q} + (AW+1)'(enc_w.n);
	assign pos_lt_len = CW'(req_data.position) < CW'(len_q);
	assign pos_a      = AW'(req_data.position);
	assign scan_fwd   = (op_q == OP_RIGHT) || (op_q == OP_DELETE);
	assign scan_stop  = scan_fwd ? (idx_q >= len_q) : (idx_q == '0);
	assign shift_up   = (op_q == OP_INSERT);

	// Shift writes follow their reads in the next cycle and take the port first.
	assign mem_we    = wr_vld_s1 || (state_q == S_ENC);
	assign mem_waddr = wr_vld_s1 ? wr_addr_s1 : cur_q + AW'(k_q);
	assign mem_wdata = wr_vld_s1 ? mem_rdata : enc_q.b[k_q];

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = src_q;
		priority if (accept && req_data.opcode == OP_READ && pos_lt_len) begin
			mem_re    = 1'b1;
			mem_raddr = pos_a;
		end else if (state_q == S_SCAN_RD && !scan_stop) begin
			mem_re    = 1'b1;
			mem_raddr = idx_q;
		end else if (state_q == S_SHIFT && more_q) begin
			mem_re    = 1'b1;
			mem_raddr = src_q;
		end else begin
			mem_re = 1'b0;
		end
	end

	assign res_valid           = (state_q == S_FIN);
	assign res_data.status     = status_q;
	assign res_data.cursor_out = 8'(cur_q);
	assign res_data.length_out = 8'(len_q);
	assign res_data.read_data  = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_READ;
			cur_q      <= '0;
			len_q      <= '0;
			idx_q      <= '0;
			src_q      <= '0;
			dist_q     <= '0;
			more_q     <= 1'b0;
			wr_vld_s1  <= 1'b0;
			wr_addr_s1 <= '0;
			enc_q      <= '0;
			k_q        <= '0;
			status_q   <= ST_SAME;
			rd_q       <= '0;
		end else begin
			wr_vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q     <= req_data.opcode;
						rd_q     <= '0;
						status_q <= ST_SAME;
						state_q  <= S_FIN;
						unique case (req_data.opcode)
							OP_INSERT: begin
								if (enc_w.n == 3'd0) begin
									status_q <= ST_REJECT;
								end else if (len_plus_n >= CAP_X) begin
									status_q <= ST_FULL;
								end else begin
									enc_q   <= enc_w;
									k_q     <= '0;
									dist_q  <= AW'(enc_w.n);
									src_q   <= len_q - 1'b1;
									more_q  <= (len_q != cur_q);
									state_q <= S_SHIFT;
								end
							end
							OP_BACKSPACE, OP_LEFT: begin
								if (cur_q != '0) begin
									idx_q   <= cur_q - 1'b1;
									state_q <= S_SCAN_RD;
								end
							end
							OP_DELETE, OP_RIGHT: begin
								if (cur_q != len_q) begin
									idx_q   <= cur_q + 1'b1;
									state_q <= S_SCAN_RD;
								end
							end
							OP_HOME: begin
								status_q <= (cur_q == '0) ? ST_SAME : ST_CHANGED;
								cur_q    <= '0;
							end
							OP_END: begin
								status_q <= (cur_q == len_q) ? ST_SAME : ST_CHANGED;
								cur_q    <= len_q;
							end
							OP_PLACE: begin
								if (pos_lt_len) begin
									idx_q   <= pos_a;
									state_q <= S_SCAN_RD;
								end else begin
									status_q <= (cur_q == len_q) ? ST_SAME : ST_CHANGED;
									cur_q    <= len_q;
								end
							end
							OP_READ: begin
								if (pos_lt_len) begin
									state_q <= S_RD_WAIT;
								end
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= scan_stop ? S_SCAN_END : S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					// step over continuation bytes
					if (mem_rdata[7:6] == 2'b10) begin
						idx_q   <= scan_fwd ? idx_q + 1'b1 : idx_q - 1'b1;
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: begin
					priority if (op_q == OP_BACKSPACE) begin
						cur_q    <= idx_q;
						dist_q   <= cur_q - idx_q;
						src_q    <= cur_q;
						more_q   <= (cur_q != len_q);
						status_q <= ST_CHANGED;
						state_q  <= S_SHIFT;
					end else if (op_q == OP_DELETE) begin
						dist_q   <= idx_q - cur_q;
						src_q    <= idx_q;
						more_q   <= (idx_q != len_q);
						status_q <= ST_CHANGED;
						state_q  <= S_SHIFT;
					end else begin
						status_q <= (idx_q == cur_q) ? ST_SAME : ST_CHANGED;
						cur_q    <= idx_q;
						state_q  <= S_FIN;
					end
				end
				S_SHIFT: begin
					if (more_q) begin
						wr_vld_s1  <= 1'b1;
						wr_addr_s1 <= shift_up ? src_q + dist_q : src_q - dist_q;
						if (shift_up) begin
							if (src_q == cur_q) begin
								more_q <= 1'b0;
							end else begin
								src_q <= src_q - 1'b1;
							end
						end else begin
							if (src_q == len_q - 1'b1) begin
								more_q <= 1'b0;
							end else begin
								src_q <= src_q + 1'b1;
							end
						end
					end else if (shift_up) begin
						state_q <= S_ENC;
					end else begin
						len_q   <= len_q - dist_q;
						state_q <= S_FIN;
					end
				end
				S_ENC: begin
					if (k_q == 2'(enc_q.n - 3'd1)) begin
						cur_q    <= cur_q + AW'(enc_q.n);
						len_q    <= len_q + AW'(enc_q.n);
						status_q <= ST_CHANGED;
						state_q  <= S_FIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_RD_WAIT: begin
					rd_q    <= mem_rdata;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ULEB_ASSERT_IMP(a_cur_in_text, clk, arst_n, 1'b1, cur_q <= len_q, "cursor past text end")
	`ULEB_ASSERT_NXT(a_idle_len_hold, clk, arst_n, state_q == S_IDLE, $stable(len_q), "length moved from idle")
	`ULEB_ASSERT_IMP(a_shift_wr_own, clk, arst_n, wr_vld_s1, state_q == S_SHIFT, "shift write outside shift")
	`ULEB_ASSERT_NXT(a_fin_to_idle, clk, arst_n, res_valid && res_ready, state_q == S_IDLE, "no idle after result")

endmodule

// ===== rtl/utf8_line_edit_buffer_top.sv =====
// Usage:
// Single-line UTF-8 edit buffer. Requests enter on req_data (opcode, codepoint,
// position) under req_valid / req_stall; one response per request leaves on
// rsp_data (status, cursor_out, length_out, read_data) under rsp_valid / rsp_stall.
// A request is taken while req_valid is high and req_stall low; req_stall is high
// while the sequencer works on a request, so one request is in flight at a time.
// Home, end, unused opcodes, refused or full inserts, reads past the length, backspace
// or left at offset 0, delete or right at the end and place at or past the length go
// straight to the response; a read inside the text first reads its byte from the store.
// Left, right and place read bytes (up to four in valid text) while looking for a
// boundary, and stop at the start or the end of the text. Backspace and delete make the
// matching move, then move the tail bytes; insert moves the tail bytes and then writes
// the encoded bytes (1-4). A new request can be taken in the cycle after the response
// register loads. The byte store moves one tail byte per cycle.
// The response register frees the sequencer: the next request is taken while a
// response is still held under rsp_stall; only a second finished response waits.
// Reset (arst_n low) empties the text and homes the cursor; the byte store is not
// cleared, since bytes at or beyond the length are never read.
`timescale 1ns / 1ps
module utf8_line_edit_buffer_top
	import uleb_pkg::*;
#(
	parameter int CAPACITY = ULEB_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	localparam int AW = $clog2(CAPACITY);

	logic          res_valid;
	logic          res_ready;
	rsp_t          res_data;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic          rsp_valid_q;
	rsp_t          rsp_data_q;

	uleb_ctrl #(
		.CAPACITY(CAPACITY),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_data(req_data),
		.req_stall(req_stall),
		.res_valid(res_valid),
		.res_data(res_data),
		.res_ready(res_ready),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	uleb_mem #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// load when empty or when the held response leaves this cycle
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_data_q <= res_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

// ===== verif/uleb_edit_check.sv =====
// Checker for the line edit buffer: predicts each response from the requests and compares.
`timescale 1ns / 1ps
module uleb_edit_check
	import uleb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req_data,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp_data,
	output int   fail_count,
	output int   pending,
	output int   req_count,
	output int   reject_count,
	output int   full_count,
	output int   peak_length
);

	localparam int MAX_REPORTS = 10;

	bit [7:0]    text_mem [ULEB_CAPACITY];
	int unsigned text_len;
	int unsigned cur_pos;
	rsp_t        expected_rsp_q [$];

	function automatic bit is_tail_byte(int unsigned idx);
		if (idx >= ULEB_CAPACITY) return 1'b0;
		return text_mem[idx][7:6] == 2'b10;
	endfunction

	// boundary at or before idx, idx already clamped to the length
	function automatic int unsigned boundary_at_or_before(int unsigned idx);
		if (idx >= text_len) return text_len;
		while (idx > 0 && is_tail_byte(idx)) idx--;
		return idx;
	endfunction

	function automatic int unsigned prev_boundary(int unsigned idx);
		if (idx == 0) return 0;
		idx--;
		while (idx > 0 && is_tail_byte(idx)) idx--;
		return idx;
	endfunction

	function automatic int unsigned next_boundary(int unsigned idx);
		if (idx >= text_len) return text_len;
		idx++;
		while (idx < text_len && is_tail_byte(idx)) idx++;
		return idx;
	endfunction

	// byte count 1..4, zero for a codepoint that may not be inserted
	function automatic int unsigned cp_to_bytes(input logic [20:0] cp,
		output logic [3:0][7:0] seq);
		int unsigned v;
		v   = 32'(cp);
		seq = '0;
		if (v < 32 || v == 127 || v > 'h10FFFF) return 0;
		if (v >= 'hD800 && v <= 'hDFFF) return 0;
		if (v < 'h80) begin
			seq[0] = 8'(v);
			return 1;
		end
		if (v < 'h800) begin
			seq[0] = 8'('hC0 | (v >> 6));
			seq[1] = 8'('h80 | (v & 'h3F));
			return 2;
		end
		if (v < 'h10000) begin
			seq[0] = 8'('hE0 | (v >> 12));
			seq[1] = 8'('h80 | ((v >> 6) & 'h3F));
			seq[2] = 8'('h80 | (v & 'h3F));
			return 3;
		end
		seq[0] = 8'('hF0 | (v >> 18));
		seq[1] = 8'('h80 | ((v >> 12) & 'h3F));
		seq[2] = 8'('h80 | ((v >> 6) & 'h3F));
		seq[3] = 8'('h80 | (v & 'h3F));
		return 4;
	endfunction

	// drop bytes [from, to) and close the gap
	function automatic void remove_span(int unsigned from, int unsigned to);
		int unsigned span;
		int unsigned i;
		span = to - from;
		for (i = from; i + span < text_len; i++) text_mem[i] = text_mem[i + span];
		text_len -= span;
	endfunction

	function automatic logic [1:0] move_cursor(int unsigned target);
		if (target == cur_pos) return ST_SAME;
		cur_pos = target;
		return ST_CHANGED;
	endfunction

	function automatic rsp_t apply_edit(req_t r);
		rsp_t            o;
		logic [3:0][7:0] seq;
		int unsigned     n;
		int unsigned     t;
		int unsigned     i;
		logic [1:0]      st;
		logic [7:0]      rd;
		st = ST_SAME;
		rd = 8'h00;
		case (r.opcode)
			OP_INSERT: begin
				n = cp_to_bytes(r.codepoint, seq);
				if (n == 0) begin
					st = ST_REJECT;
				end else if (text_len + n >= ULEB_CAPACITY) begin
					st = ST_FULL;
				end else begin
					cur_pos = boundary_at_or_before(cur_pos > text_len ? text_len : cur_pos);
					for (i = text_len; i > cur_pos; i--) text_mem[i - 1 + n] = text_mem[i - 1];
					for (i = 0; i < n; i++) text_mem[cur_pos + i] = seq[i];
					cur_pos  += n;
					text_len += n;
					st = ST_CHANGED;
				end
			end
			OP_BACKSPACE: begin
				if (cur_pos > 0 && text_len > 0) begin
					t = prev_boundary(cur_pos);
					remove_span(t, cur_pos);
					cur_pos = t;
					st = ST_CHANGED;
				end
			end
			OP_DELETE: begin
				if (cur_pos < text_len) begin
					remove_span(cur_pos, next_boundary(cur_pos));
					st = ST_CHANGED;
				end
			end
			OP_LEFT:  st = move_cursor(prev_boundary(cur_pos));
			OP_RIGHT: st = move_cursor(next_boundary(cur_pos));
			OP_HOME:  st = move_cursor(0);
			OP_END:   st = move_cursor(text_len);
			OP_PLACE: begin
				t  = 32'(r.position);
				st = move_cursor(boundary_at_or_before(t > text_len ? text_len : t));
			end
			OP_READ: begin
				if (r.position < text_len) rd = text_mem[r.position];
			end
			default: ;
		endcase
		o.status     = st;
		o.cursor_out = 8'(cur_pos);
		o.length_out = 8'(text_len);
		o.read_data  = rd;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			text_len     = 0;
			cur_pos      = 0;
			expected_rsp_q.delete();
			fail_count   = 0;
			req_count    = 0;
			reject_count = 0;
			full_count   = 0;
			peak_length  = 0;
		end else begin
			// compare first: a response taken now belongs to an older request
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: response with no request outstanding: %s",
							$realtime,
							$sformatf("st=%0d cur=%0d len=%0d rd=%02h",
								rsp_data.status, rsp_data.cursor_out,
								rsp_data.length_out, rsp_data.read_data));
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp_data.status !== want.status ||
						rsp_data.cursor_out !== want.cursor_out ||
						rsp_data.length_out !== want.length_out ||
						rsp_data.read_data !== want.read_data) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("%0t: mismatch exp %s, got %s", $realtime,
								$sformatf("st=%0d cur=%0d len=%0d rd=%02h",
									want.status, want.cursor_out,
									want.length_out, want.read_data),
								$sformatf("st=%0d cur=%0d len=%0d rd=%02h",
									rsp_data.status, rsp_data.cursor_out,
									rsp_data.length_out, rsp_data.read_data));
					end
				end
			end
			if (req_valid && !req_stall) begin
				want = apply_edit(req_data);
				expected_rsp_q.push_back(want);
				req_count++;
				if (want.status == ST_REJECT) reject_count++;
				if (want.status == ST_FULL) full_count++;
				if (int'(text_len) > peak_length) peak_length = int'(text_len);
			end
		end
		pending = expected_rsp_q.size();
	end

endmodule

// ===== verif/tb_utf8_line_edit_buffer_top.sv =====
// Testbench top for the line edit buffer: request stimulus, response stalls and the verdict.
`timescale 1ns / 1ps
module tb_utf8_line_edit_buffer_top;
	import uleb_pkg::*;

	localparam logic [3:0] OP_FIRST_UNUSED = 4'd9;
	localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;
	localparam int RAND_ITEMS      = 1050;
	localparam int BURST_ITEMS     = 16;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int IDLE_LIMIT      = 5000;
	localparam int BIAS_GROW       = 0;
	localparam int BIAS_SHRINK     = 1;
	localparam int BIAS_MIXED      = 2;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	req_t req_data  = '0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp_data;

	int fail_count;
	int pending;
	int req_count;
	int reject_count;
	int full_count;
	int peak_length;
	int idle_cycles  = 0;
	int hold_off_seq = 0;
	bit hold_active  = 1'b0;
	bit tx_quiet     = 1'b0;
	bit rx_quiet     = 1'b0;

	utf8_line_edit_buffer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	uleb_edit_check u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_data     (req_data),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp_data     (rsp_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.req_count    (req_count),
		.reject_count (reject_count),
		.full_count   (full_count),
		.peak_length  (peak_length)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [20:0] rand_codepoint();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) return 21'($urandom_range(32, 126));
		if (pick < 50) return 21'($urandom_range('h80, 'h7FF));
		if (pick < 68) return 21'($urandom_range('h800, 'hFFFF));
		if (pick < 86) return 21'($urandom_range('h10000, 'h10FFFF));
		if (pick < 90) return $urandom_range(0, 1) ? 21'($urandom_range(0, 31)) : 21'd127;
		if (pick < 95) return 21'($urandom_range('hD800, 'hDFFF));
		return 21'($urandom_range('h110000, 'h1FFFFF));
	endfunction

	function automatic req_t mk_req(logic [3:0] op, logic [20:0] cp, logic [7:0] pos);
		req_t r;
		r.opcode    = op;
		r.codepoint = cp;
		r.position  = pos;
		return r;
	endfunction

	function automatic req_t rand_edit(int bias);
		int         ins_pct;
		int         del_pct;
		int         pick;
		logic [3:0] op;
		logic [7:0] pos;
		case (bias)
			BIAS_GROW: begin
				ins_pct = 70;
				del_pct = 16;
			end
			BIAS_SHRINK: begin
				ins_pct = 15;
				del_pct = 55;
			end
			default: begin
				ins_pct = 30;
				del_pct = 20;
			end
		endcase
		pick = $urandom_range(0, 99);
		if (pick < ins_pct) begin
			op = OP_INSERT;
		end else if (pick < ins_pct + del_pct) begin
			op = pick[0] ? OP_BACKSPACE : OP_DELETE;
		end else begin
			case ($urandom_range(0, 7))
				0, 1:    op = OP_LEFT;
				2, 3:    op = OP_RIGHT;
				4:       op = OP_HOME;
				5:       op = OP_END;
				6:       op = OP_PLACE;
				default: op = OP_READ;
			endcase
		end
		if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		else pos = 8'($urandom_range(0, 255));
		return mk_req(op, rand_codepoint(), pos);
	endfunction

	// present one request and hold it until taken; leave valid high if no gap follows
	task automatic offer_req(input req_t r);
		int g;
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		g = tx_quiet ? 0 : gap_cycles();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// response side stalls, with a long hold-off when the stimulus asks for one
	initial begin
		int seen_hold;
		int g;
		int loops;
		seen_hold = 0;
		loops     = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_seq != seen_hold) begin
				seen_hold   = hold_off_seq;
				hold_active = 1'b1;
				rsp_stall  <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end
			if (loops % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
			loops++;
			g = rx_quiet ? 0 : gap_cycles();
			if (g > 0) begin
				rsp_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no handshake for %0d cycles", IDLE_LIMIT);
			$display("[utf8_line_edit_buffer_top] ERROR");
			$finish;
		end
	end

	initial begin
		int done;
		int phase;
		int bias;
		int len;
		int k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty buffer corners
		offer_req(mk_req(OP_BACKSPACE, 21'd0, 8'h00));
		offer_req(mk_req(OP_DELETE, 21'd0, 8'h00));
		offer_req(mk_req(OP_LEFT, 21'd0, 8'h00));
		offer_req(mk_req(OP_RIGHT, 21'd0, 8'h00));
		offer_req(mk_req(OP_PLACE, 21'd0, 8'hFF));
		// codepoints that must be refused
		offer_req(mk_req(OP_INSERT, 21'd0, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'd31, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'd127, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'h00D800, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'h00DFFF, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'h110000, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'h1FFFFF, 8'hFF));
		// edges of every encoding length
		offer_req(mk_req(OP_INSERT, 21'd32, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'h000080, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'h0007FF, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'h000800, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'h00FFFF, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'h010000, 8'h00));
		offer_req(mk_req(OP_INSERT, 21'h10FFFF, 8'h00));
		offer_req(mk_req(OP_LEFT, 21'd0, 8'h00));
		// offset 2 falls inside the two-byte character and snaps back
		offer_req(mk_req(OP_PLACE, 21'd0, 8'h02));
		offer_req(mk_req(OP_READ, 21'd0, 8'h01));
		offer_req(mk_req(OP_BACKSPACE, 21'd0, 8'h00));
		offer_req(mk_req(OP_DELETE, 21'd0, 8'h00));
		offer_req(mk_req(OP_HOME, 21'd0, 8'h00));
		offer_req(mk_req(OP_END, 21'd0, 8'h00));
		offer_req(mk_req(OP_LAST_UNUSED, 21'h1FFFFF, 8'hFF));

		done  = 0;
		phase = 0;
		while (done < RAND_ITEMS) begin
			bias     = (phase == 0) ? BIAS_GROW : $urandom_range(BIAS_GROW, BIAS_MIXED);
			len      = (phase == 0) ? 240 : $urandom_range(60, 160);
			tx_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				// hold off the receiver and keep offering so the block backs up
				req_valid <= 1'b0;
				tx_quiet   = 1'b1;
				hold_off_seq++;
				@(posedge clk);
				wait (hold_active);
				repeat (BURST_ITEMS) offer_req(rand_edit(BIAS_MIXED));
				done += BURST_ITEMS;
			end
			for (k = 0; k < len && done < RAND_ITEMS; k++) begin
				if ($urandom_range(0, 32) == 0) begin
					offer_req(mk_req(4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)),
						rand_codepoint(), 8'($urandom)));
				end else begin
					offer_req(rand_edit(bias));
					done++;
				end
			end
			if (phase == 1 || $urandom_range(0, 2) == 0) begin
				// pause requests until every response is back
				req_valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
			end
			phase++;
		end

		req_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		$display("run: %0d requests checked, %0d refused codepoints, %0d inserts into a full buffer",
			req_count, reject_count, full_count);
		$display("run: longest text %0d bytes, %0d mismatches", peak_length, fail_count);
		if (fail_count == 0)
			$display("[utf8_line_edit_buffer_top] OK");
		else
			$display("[utf8_line_edit_buffer_top] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/uleb_pkg.sv
rtl/uleb_mem.sv
rtl/uleb_ctrl.sv
rtl/utf8_line_edit_buffer_top.sv
verif/uleb_edit_check.sv
verif/tb_utf8_line_edit_buffer_top.sv
